// ===== rtl/core/h264fua_pkg.sv =====
// shared types and constants for the h.264 avc rtp fu-a packetizer
// no dependencies; top, parser, queue and emitter use it by scoped name
package h264fua_pkg;

   // nal / fu-a framing constants
   localparam logic [4:0]  FU_A_TYPE     = 5'd28;
   localparam logic [2:0]  PREFIX_RESET  = 3'd4;
   localparam logic [2:0]  PREFIX_MIN    = 3'd1;
   localparam logic [2:0]  PREFIX_MAX    = 3'd4;
   localparam logic [11:0] MTU_RESET     = 12'd1400;
   localparam logic [11:0] MTU_MIN       = 12'd3;
   localparam logic [11:0] FU_HDR_BYTES  = 12'd2;

   // register map: index taken from paddr bit 2
   localparam logic CSR_IDX_PREFIX = 1'b0;
   localparam logic CSR_IDX_MTU    = 1'b1;

   // command queue between parser and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_LEN    = 3'd0,
      PH_SKIP   = 3'd1,
      PH_DROP   = 3'd2,
      PH_SINGLE = 3'd3,
      PH_FUHDR  = 3'd4,
      PH_FUBODY = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      BEAT_IND  = 2'd0,
      BEAT_HDR  = 2'd1,
      BEAT_DATA = 2'd2
   } beat_type;

   // one parsed input byte: either a single payload beat or fu indicator,
   // fu header and payload beat
   typedef struct packed {
      logic       fu_pair;
      logic [7:0] fu_ind;
      logic [7:0] fu_hdr;
      logic [7:0] data;
      logic       data_end;
      logic       marker;
   } cmd_type;

endpackage

// ===== rtl/core/h264_avc_rtp_fua_packetizer.sv =====
// h.264 avc rtp packetizer: single nal and fu-a modes, one input byte per beat
// path: an accepted item is written into the command queue, and the emitter then
// loads its beats into the rsp output register, fu-a header beats first
// throughput: one input byte per cycle; each fu-a fragment adds two header beats on
// rsp, and req stalls only when the four-entry command queue between parser and
// emitter is full. reset is synchronous: parse state, queue and output clear at once,
// registers return to 4 prefix bytes and an mtu of 1400
module h264_avc_rtp_fua_packetizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_in_buffer,
   input  logic [23:0] req_buffer_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_packet_end,
   output logic        rsp_marker,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0]  prefix_bytes_ff, prefix_bytes_in;
   logic [11:0] mtu_bytes_ff, mtu_bytes_in;
   logic        csr_write;

   logic                 queue_full;
   logic                 queue_push;
   h264fua_pkg::cmd_type queue_push_cmd;
   logic                 queue_pop;
   logic                 queue_not_empty;
   h264fua_pkg::cmd_type queue_head_cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prefix_bytes_in = prefix_bytes_ff;
      mtu_bytes_in    = mtu_bytes_ff;
      if (csr_write) begin
         if (paddr[2] == h264fua_pkg::CSR_IDX_PREFIX) begin
            prefix_bytes_in = pwdata[2:0];
         end else begin
            mtu_bytes_in = pwdata[11:0];
         end
      end
      prdata = (paddr[2] == h264fua_pkg::CSR_IDX_MTU) ? {20'd0, mtu_bytes_ff}
                                                       : {29'd0, prefix_bytes_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_bytes_ff <= h264fua_pkg::PREFIX_RESET;
         mtu_bytes_ff    <= h264fua_pkg::MTU_RESET;
      end else begin
         prefix_bytes_ff <= prefix_bytes_in;
         mtu_bytes_ff    <= mtu_bytes_in;
      end
   end

   h264fua_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_in_buffer (req_last_in_buffer),
      .req_buffer_length  (req_buffer_length),
      .cfg_prefix_bytes   (prefix_bytes_ff),
      .cfg_mtu_bytes      (mtu_bytes_ff),
      .queue_full         (queue_full),
      .push               (queue_push),
      .push_cmd           (queue_push_cmd)
   );

   h264fua_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_cmd  (queue_push_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head_cmd  (queue_head_cmd)
   );

   h264fua_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (queue_not_empty),
      .head_cmd         (queue_head_cmd),
      .pop              (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_marker       (rsp_marker)
   );

endmodule

// ===== rtl/core/h264fua_front.sv =====
// parser: walks length prefixes and nal bodies, one byte per beat, and
// turns each payload byte into a packet command. depends on h264fua_pkg
module h264fua_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_in_buffer,
   input  logic [23:0]          req_buffer_length,
   input  logic [2:0]           cfg_prefix_bytes,
   input  logic [11:0]          cfg_mtu_bytes,
   input  logic                 queue_full,
   output logic                 push,
   output h264fua_pkg::cmd_type push_cmd
);

   h264fua_pkg::phase_type phase_ff, phase_in;
   logic [23:0] accum_ff, accum_in;
   logic [1:0]  prefix_cnt_ff, prefix_cnt_in;
   logic [23:0] rem_ff, rem_in;
   logic [11:0] fill_ff, fill_in;
   logic [7:0]  fu_ind_ff, fu_ind_in;
   logic [4:0]  nal_kind_ff, nal_kind_in;
   logic        first_frag_ff, first_frag_in;

   logic        accept;
   logic [2:0]  plen;
   logic [11:0] mtu;
   logic [11:0] pay;
   logic [23:0] rem_dec;
   logic [31:0] size;
   logic        lastfrag;
   logic [11:0] fill_inc;
   logic        body_end;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      if (cfg_prefix_bytes < h264fua_pkg::PREFIX_MIN) begin
         plen = h264fua_pkg::PREFIX_MIN;
      end else if (cfg_prefix_bytes > h264fua_pkg::PREFIX_MAX) begin
         plen = h264fua_pkg::PREFIX_MAX;
      end else begin
         plen = cfg_prefix_bytes;
      end
      mtu = (cfg_mtu_bytes < h264fua_pkg::MTU_MIN) ? h264fua_pkg::MTU_MIN : cfg_mtu_bytes;
      pay = mtu - h264fua_pkg::FU_HDR_BYTES;
   end

   assign rem_dec  = (rem_ff == 24'd0) ? 24'd0 : rem_ff - 24'd1;
   assign size     = {accum_ff, req_data_byte};
   // rem + fill stays constant across one fragment, so this holds per packet
   assign lastfrag = ({1'b0, rem_ff} + {13'd0, fill_ff}) <= {13'd0, pay};
   assign fill_inc = fill_ff + 12'd1;
   assign body_end = (rem_dec == 24'd0) || (fill_inc >= pay) || req_last_in_buffer;

   always_comb begin
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      prefix_cnt_in = prefix_cnt_ff;
      rem_in        = rem_ff;
      fill_in       = fill_ff;
      fu_ind_in     = fu_ind_ff;
      nal_kind_in   = nal_kind_ff;
      first_frag_in = first_frag_ff;
      push          = 1'b0;
      push_cmd      = '0;
      push_cmd.data = req_data_byte;

      if (accept) begin
         case (phase_ff)
            h264fua_pkg::PH_SKIP: begin
               phase_in = h264fua_pkg::PH_LEN;
            end
            h264fua_pkg::PH_DROP: begin
               phase_in = h264fua_pkg::PH_DROP;
            end
            h264fua_pkg::PH_SINGLE: begin
               rem_in            = rem_dec;
               push              = 1'b1;
               push_cmd.data_end = (rem_dec == 24'd0) || req_last_in_buffer;
               push_cmd.marker   = 1'b1;
               if (rem_dec == 24'd0) begin
                  phase_in = h264fua_pkg::PH_LEN;
               end
            end
            h264fua_pkg::PH_FUHDR: begin
               fu_ind_in     = {req_data_byte[7:5], h264fua_pkg::FU_A_TYPE};
               nal_kind_in   = req_data_byte[4:0];
               first_frag_in = 1'b1;
               fill_in       = 12'd0;
               rem_in        = rem_dec;
               phase_in      = (rem_dec != 24'd0) ? h264fua_pkg::PH_FUBODY
                                                  : h264fua_pkg::PH_LEN;
            end
            h264fua_pkg::PH_FUBODY: begin
               push              = 1'b1;
               push_cmd.fu_pair  = (fill_ff == 12'd0);
               push_cmd.fu_ind   = fu_ind_ff;
               push_cmd.fu_hdr   = {first_frag_ff, lastfrag, 1'b0, nal_kind_ff};
               push_cmd.data_end = body_end;
               push_cmd.marker   = lastfrag;
               if (fill_ff == 12'd0) begin
                  first_frag_in = 1'b0;
               end
               rem_in  = rem_dec;
               fill_in = body_end ? 12'd0 : fill_inc;
               if (rem_dec == 24'd0) begin
                  phase_in      = h264fua_pkg::PH_LEN;
                  first_frag_in = 1'b1;
               end
            end
            default: begin
               // length prefix byte; unused phase codes land here too
               phase_in = h264fua_pkg::PH_LEN;
               if (({1'b0, prefix_cnt_ff} + 3'd1) >= plen) begin
                  accum_in      = 24'd0;
                  prefix_cnt_in = 2'd0;
                  if (size == 32'd1) begin
                     phase_in = h264fua_pkg::PH_SKIP;
                  end else if (size == 32'd0 || size > {8'd0, req_buffer_length}) begin
                     phase_in = h264fua_pkg::PH_DROP;
                  end else begin
                     rem_in   = size[23:0];
                     fill_in  = 12'd0;
                     phase_in = (size <= {20'd0, mtu}) ? h264fua_pkg::PH_SINGLE
                                                       : h264fua_pkg::PH_FUHDR;
                  end
               end else begin
                  accum_in      = size[23:0];
                  prefix_cnt_in = prefix_cnt_ff + 2'd1;
               end
            end
         endcase

         if (req_last_in_buffer) begin
            phase_in      = h264fua_pkg::PH_LEN;
            accum_in      = 24'd0;
            prefix_cnt_in = 2'd0;
            rem_in        = 24'd0;
            fill_in       = 12'd0;
            first_frag_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= h264fua_pkg::PH_LEN;
         accum_ff      <= 24'd0;
         prefix_cnt_ff <= 2'd0;
         rem_ff        <= 24'd0;
         fill_ff       <= 12'd0;
         fu_ind_ff     <= 8'd0;
         nal_kind_ff   <= 5'd0;
         first_frag_ff <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         prefix_cnt_ff <= prefix_cnt_in;
         rem_ff        <= rem_in;
         fill_ff       <= fill_in;
         fu_ind_ff     <= fu_ind_in;
         nal_kind_ff   <= nal_kind_in;
         first_frag_ff <= first_frag_in;
      end
   end

endmodule

// ===== rtl/core/h264fua_queue.sv =====
// short command queue between parser and emitter
// depends on h264fua_pkg for the command type and depth
module h264fua_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  h264fua_pkg::cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output h264fua_pkg::cmd_type head_cmd
);

   h264fua_pkg::cmd_type entry_ff [h264fua_pkg::QUEUE_DEPTH];
   logic [h264fua_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [h264fua_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [h264fua_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == h264fua_pkg::QUEUE_CNT_W'(h264fua_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/h264fua_back.sv =====
// emitter: expands queued commands into output beats through an
// output register. depends on h264fua_pkg
module h264fua_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  h264fua_pkg::cmd_type head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_packet_end,
   output logic                 rsp_marker
);

   h264fua_pkg::beat_type beat_ff, beat_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       out_mark_ff, out_mark_in;
   logic       load;

   assign load = !out_valid_ff || !rsp_stall;

   always_comb begin
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_mark_in  = out_mark_ff;
      pop          = 1'b0;
      if (load) begin
         out_valid_in = not_empty;
         out_mark_in  = head_cmd.marker;
         out_byte_in  = head_cmd.data;
         out_end_in   = head_cmd.data_end;
         if (not_empty) begin
            if (head_cmd.fu_pair) begin
               case (beat_ff)
                  h264fua_pkg::BEAT_IND: begin
                     out_byte_in = head_cmd.fu_ind;
                     out_end_in  = 1'b0;
                     beat_in     = h264fua_pkg::BEAT_HDR;
                  end
                  h264fua_pkg::BEAT_HDR: begin
                     out_byte_in = head_cmd.fu_hdr;
                     out_end_in  = 1'b0;
                     beat_in     = h264fua_pkg::BEAT_DATA;
                  end
                  default: begin
                     pop     = 1'b1;
                     beat_in = h264fua_pkg::BEAT_IND;
                  end
               endcase
            end else begin
               pop     = 1'b1;
               beat_in = h264fua_pkg::BEAT_IND;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= h264fua_pkg::BEAT_IND;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_mark_ff <= out_mark_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_packet_end   = out_end_ff;
   assign rsp_marker       = out_mark_ff;

endmodule

// ===== rtl/core/h264fua_checker.sv =====
// port-level checks for the packetizer, attached by bind below
// no dependencies beyond the top level's port list
module h264fua_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_packet_end,
   input logic        rsp_marker,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_packet_end)
         && $stable(rsp_marker))
      else $error("stalled rsp beat changed");

   // nothing is shown in the cycle after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // consecutive beats of one packet carry the same marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_packet_end ##1 rsp_valid |->
         rsp_marker == $past(rsp_marker))
      else $error("marker changed inside a packet");

   // mtu register reads back what was written
   assert property (@(posedge clock) disable iff (reset)
      $past(psel && penable && pwrite && pready && paddr[2]) && paddr[2] |->
         prdata[11:0] == $past(pwdata[11:0]))
      else $error("mtu register readback mismatch");

endmodule

bind h264_avc_rtp_fua_packetizer h264fua_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for h264_avc_rtp_fua_packetizer: directed and random
// length-prefixed buffers, with an in-line packetizer predictor; needs h264fua_pkg
module tb;

   localparam int ITEM_TARGET = 270;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic [7:0] payload;
      logic       pkt_end;
      logic       marker;
   } pkt_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_in_buffer;
   logic [23:0] req_buffer_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_packet_end;
   logic        rsp_marker;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // predictor copy of registers and parse state
   logic [2:0]  prefix_reg;
   logic [11:0] mtu_reg;
   h264fua_pkg::phase_type ph;
   logic [31:0] len_acc;
   logic [1:0]  pfx_cnt;
   logic [23:0] remaining;
   logic [11:0] fill;
   logic [7:0]  fu_ind;
   logic [4:0]  nal_kind;
   logic        first_frag;

   pkt_beat_type expected_beats[$];
   int          error_count = 0;
   int          items_used = 0;
   int          beats_checked = 0;
   int          settings_used = 0;
   int          cycle_count = 0;
   int          hold_cycles = 0;
   bit          gaps_on = 1'b1;

   h264_avc_rtp_fua_packetizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_in_buffer (req_last_in_buffer),
      .req_buffer_length  (req_buffer_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_marker         (rsp_marker),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #4 clock = ~clock;

   function automatic void clear_parse();
      ph = h264fua_pkg::PH_LEN;
      len_acc = '0;
      pfx_cnt = '0;
      remaining = '0;
      fill = '0;
      first_frag = 1'b1;
   endfunction

   function automatic void push_beat(input logic [7:0] b, input logic e, input logic mk);
      pkt_beat_type beat;
      beat.payload = b;
      beat.pkt_end = e;
      beat.marker = mk;
      expected_beats.push_back(beat);
   endfunction

   // advance the predictor by one accepted byte
   function automatic void packetize_byte(input logic [7:0] b, input logic lst,
                                          input logic [23:0] blen);
      int unsigned plen;
      int unsigned mtu;
      int unsigned pay;
      int unsigned size;
      logic        lastfrag;
      logic        pend;
      logic [7:0]  hdr;
      plen = prefix_reg;
      if (plen < 1) plen = 1;
      if (plen > 4) plen = 4;
      mtu = (mtu_reg < 3) ? 3 : mtu_reg;
      pay = mtu - 2;
      case (ph)
         h264fua_pkg::PH_SKIP: ph = h264fua_pkg::PH_LEN;
         h264fua_pkg::PH_DROP: ;
         h264fua_pkg::PH_SINGLE: begin
            if (remaining != 0) remaining--;
            push_beat(b, remaining == 0 || lst, 1'b1);
            if (remaining == 0) ph = h264fua_pkg::PH_LEN;
         end
         h264fua_pkg::PH_FUHDR: begin
            // nal header is not sent, only its f and nri bits and its type
            fu_ind = {b[7:5], h264fua_pkg::FU_A_TYPE};
            nal_kind = b[4:0];
            first_frag = 1'b1;
            fill = '0;
            if (remaining != 0) remaining--;
            ph = (remaining != 0) ? h264fua_pkg::PH_FUBODY : h264fua_pkg::PH_LEN;
         end
         h264fua_pkg::PH_FUBODY: begin
            lastfrag = (remaining + fill <= pay);
            if (fill == 0) begin
               hdr = {first_frag, lastfrag, 1'b0, nal_kind};
               push_beat(fu_ind, 1'b0, lastfrag);
               push_beat(hdr, 1'b0, lastfrag);
               first_frag = 1'b0;
            end
            if (remaining != 0) remaining--;
            fill = fill + 1'b1;
            pend = (remaining == 0) || (fill >= pay) || lst;
            push_beat(b, pend, lastfrag);
            if (pend) fill = '0;
            if (remaining == 0) begin
               ph = h264fua_pkg::PH_LEN;
               first_frag = 1'b1;
            end
         end
         default: begin
            ph = h264fua_pkg::PH_LEN;
            len_acc = {len_acc[23:0], b};
            if (pfx_cnt + 1 >= plen) begin
               size = len_acc;
               len_acc = '0;
               pfx_cnt = '0;
               if (size == 1) begin
                  ph = h264fua_pkg::PH_SKIP;
               end else if (size == 0 || size > blen) begin
                  ph = h264fua_pkg::PH_DROP;
               end else begin
                  remaining = 24'(size);
                  fill = '0;
                  ph = (size <= mtu) ? h264fua_pkg::PH_SINGLE : h264fua_pkg::PH_FUHDR;
               end
            end else begin
               pfx_cnt = pfx_cnt + 1'b1;
            end
         end
      endcase
      if (lst) clear_parse();
   endfunction

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_idx == h264fua_pkg::CSR_IDX_PREFIX) prefix_reg = value[2:0];
      else mtu_reg = value[11:0];
      settings_used++;
      @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic lst, input logic [23:0] blen);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_in_buffer <= lst;
      req_buffer_length <= blen;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      packetize_byte(b, lst, blen);
      items_used++;
   endtask

   task automatic send_buffer(input logic [7:0] au[$], input logic [23:0] blen);
      for (int i = 0; i < au.size(); i++)
         send_byte(au[i], i == au.size() - 1, blen);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      // parse-only bytes may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // skip, single nal, zero length and oversize length
   task automatic test_length_codes();
      logic [7:0] au[$];
      csr_write(h264fua_pkg::CSR_IDX_PREFIX, 32'd0);
      csr_write(h264fua_pkg::CSR_IDX_MTU, 32'd8);
      au = {8'd1, 8'hFF, 8'd2, 8'h00, 8'hFF, 8'd0, 8'h11, 8'h22};
      send_buffer(au, 24'd8);
      au = {8'hC8, 8'h55, 8'hAA};
      send_buffer(au, 24'd3);
      wait_idle();
   endtask

   // fu-a split at the smallest mtu, four-byte prefix from an oversize setting
   task automatic test_fu_a_split();
      logic [7:0] au[$];
      csr_write(h264fua_pkg::CSR_IDX_PREFIX, 32'd7);
      csr_write(h264fua_pkg::CSR_IDX_MTU, 32'd0);
      au = {8'd0, 8'd0, 8'd0, 8'd5, 8'hE5, 8'h00, 8'hFF, 8'h3C, 8'h81};
      send_buffer(au, 24'd9);
      wait_idle();
   endtask

   // buffer ends inside a fragment, inside a prefix, and after one byte
   task automatic test_buffer_truncation();
      logic [7:0] au[$];
      csr_write(h264fua_pkg::CSR_IDX_MTU, 32'd6);
      au = {8'd0, 8'd0, 8'd0, 8'd9, 8'h7C, 8'hA0, 8'h5A};
      send_buffer(au, 24'hFFFFFF);
      au = {8'h00, 8'h12};
      send_buffer(au, 24'd2);
      au = {8'hFF};
      send_buffer(au, 24'd1);
      wait_idle();
   endtask

   // long output hold-off while input keeps coming
   task automatic test_backpressure();
      logic [7:0] au[$];
      gaps_on = 1'b0;
      csr_write(h264fua_pkg::CSR_IDX_PREFIX, 32'd2);
      csr_write(h264fua_pkg::CSR_IDX_MTU, 32'd5);
      au = {8'd0, 8'd30};
      repeat (30) au.push_back(8'($urandom));
      hold_cycles = 80;
      send_buffer(au, 24'($urandom_range(32, 24'hFFFFFF)));
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic send_random_buffer(input int unsigned plen, input int unsigned mtu);
      logic [7:0]  au[$];
      logic [23:0] blen;
      int unsigned kind;
      int unsigned len;
      int unsigned lim;
      int unsigned total;
      kind = $urandom_range(0, 9);
      lim = (3 * mtu > 48) ? 48 : 3 * mtu;
      if (kind == 0) begin
         // noise: random bytes and a random declared length
         repeat ($urandom_range(1, 16)) au.push_back(8'($urandom));
         blen = 24'($urandom_range(1, 24'hFFFFFF));
      end else begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 19))
               0: len = 0;
               1: len = 1;
               2: len = (mtu > 48) ? 48 : mtu;
               3: len = (mtu + 1 > 48) ? 48 : mtu + 1;
               default: len = $urandom_range(2, lim);
            endcase
            for (int k = plen - 1; k >= 0; k--) au.push_back(8'(len >> (8 * k)));
            repeat (len) au.push_back(8'($urandom));
         end
         total = au.size();
         blen = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(total, 24'hFFFFFF))
                                            : 24'(total);
         // broken buffer: cut short anywhere
         if (kind == 1 && au.size() > 1)
            repeat ($urandom_range(1, au.size() - 1)) void'(au.pop_back());
      end
      send_buffer(au, blen);
   endtask

   task automatic test_random_streams();
      int unsigned pf;
      int unsigned mt;
      int unsigned plen;
      int unsigned mtu;
      int          round;
      round = 0;
      while (items_used < ITEM_TARGET) begin
         gaps_on = (items_used < ITEM_TARGET - 50);
         if (round == 0) begin
            pf = 4;
            mt = 4095;
         end else if (round == 1) begin
            pf = 1;
            mt = 3;
         end else begin
            case ($urandom_range(0, 9))
               0: pf = 0;
               1: pf = $urandom_range(5, 7);
               default: pf = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 9))
               0: mt = $urandom_range(0, 2);
               1: mt = 4095;
               2: mt = 1400;
               default: mt = $urandom_range(3, 24);
            endcase
         end
         csr_write(h264fua_pkg::CSR_IDX_PREFIX, pf);
         csr_write(h264fua_pkg::CSR_IDX_MTU, mt);
         plen = (pf < 1) ? 1 : (pf > 4) ? 4 : pf;
         mtu = (mt < 3) ? 3 : mt;
         repeat ($urandom_range(1, 3))
            if (items_used < ITEM_TARGET) send_random_buffer(plen, mtu);
         wait_idle();
         round++;
      end
   endtask

   // output side: random stall bursts, or one long hold when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      pkt_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat: expected none, got byte %02h end %b marker %b",
                     $time, rsp_payload_byte, rsp_packet_end, rsp_marker);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (rsp_payload_byte !== want.payload) begin
               $display("%0t: payload_byte expected %02h got %02h",
                        $time, want.payload, rsp_payload_byte);
               error_count++;
            end
            if (rsp_packet_end !== want.pkt_end) begin
               $display("%0t: packet_end expected %b got %b",
                        $time, want.pkt_end, rsp_packet_end);
               error_count++;
            end
            if (rsp_marker !== want.marker) begin
               $display("%0t: marker expected %b got %b", $time, want.marker, rsp_marker);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats still expected", $time, expected_beats.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_last_in_buffer = 1'b0;
      req_buffer_length = 24'd1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      prefix_reg = h264fua_pkg::PREFIX_RESET;
      mtu_reg = h264fua_pkg::MTU_RESET;
      fu_ind = '0;
      nal_kind = '0;
      clear_parse();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_length_codes();
      test_fu_a_split();
      test_buffer_truncation();
      test_backpressure();
      test_random_streams();

      wait_idle();
      if (expected_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
         error_count++;
      end
      $display("checked %0d output beats from %0d input bytes", beats_checked,
               items_used);
      $display("across %0d register writes, fu-a and single nal paths included",
               settings_used);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
